[rtl/core/gmp_pkg.sv]
// ----------------------------------------------------------------------------
// gmp_pkg
// Shared types and constants for the grid maximum path sum block.
// ----------------------------------------------------------------------------
package gmp_pkg;

	localparam int MAX_ROWS_DEF = 32;
	localparam int MAX_COLS_DEF = 32;

	localparam int CELL_W  = 16;
	localparam int SUM_W   = 22;
	localparam int COORD_W = 5;
	localparam int SIZE_W  = 6;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = SIZE_W;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'd1;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// One classified cell on its way from the front to the back.
	typedef struct packed {
		logic                     last;
		logic [COORD_W-1:0]       row;
		logic [COORD_W-1:0]       col;
		logic                     from_left;
		logic signed [SUM_W-1:0]  sum;
	} gmp_entry_t;

	// Zero reads as one, anything above the limit reads as the limit.
	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
	                                                 input int hi);
		logic [SIZE_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = SIZE_W'(1);
		end else if (int'(v) > hi) begin
			r = SIZE_W'(hi);
		end
		return r;
	endfunction

endpackage

[rtl/core/gmp_front.sv]
// ----------------------------------------------------------------------------
// gmp_front
// Takes grid cells, runs the best-sum recurrence with a one-row line buffer
// and hands each classified cell to the back queue.
// ----------------------------------------------------------------------------
module gmp_front #(
	parameter int MAX_ROWS = gmp_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = gmp_pkg::MAX_COLS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	input  logic signed [gmp_pkg::CELL_W-1:0]       cell_value,
	output logic                                    in_stall,
	input  logic                                    cfg_we,
	input  logic [gmp_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [gmp_pkg::CFG_DATA_W-1:0]          cfg_data,
	output logic                                    push,
	output gmp_pkg::gmp_entry_t                     push_entry,
	input  logic                                    q_full
);
	import gmp_pkg::*;

	localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	logic [SIZE_W-1:0]        row_count_q, col_count_q;
	logic [COORD_W-1:0]       load_row_q, load_col_q;
	logic signed [SUM_W-1:0]  left_sum_q;
	logic signed [SUM_W-1:0]  row_sum_q [MAX_COLS];

	logic [SIZE_W-1:0]        rows, cols;
	logic signed [SUM_W-1:0]  above, v_ext, sum;
	logic                     from_left, last_col, last_row, accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	always_comb begin
		rows     = clamp_size(row_count_q, MAX_ROWS);
		cols     = clamp_size(col_count_q, MAX_COLS);
		above    = row_sum_q[load_col_q[CIW-1:0]];
		v_ext    = SUM_W'(cell_value);
		last_col = ({1'b0, load_col_q} == cols - SIZE_W'(1));
		last_row = ({1'b0, load_row_q} == rows - SIZE_W'(1));
		if (load_row_q == '0 && load_col_q == '0) begin
			sum       = v_ext;
			from_left = 1'b0;
		end else if (load_row_q == '0) begin
			sum       = left_sum_q + v_ext;
			from_left = 1'b1;
		end else if (load_col_q == '0) begin
			sum       = above + v_ext;
			from_left = 1'b0;
		end else if (above < left_sum_q) begin
			sum       = left_sum_q + v_ext;
			from_left = 1'b1;
		end else begin
			// tie goes up
			sum       = above + v_ext;
			from_left = 1'b0;
		end
	end

	assign push                 = accept;
	assign push_entry.last      = last_col && last_row;
	assign push_entry.row       = load_row_q;
	assign push_entry.col       = load_col_q;
	assign push_entry.from_left = from_left;
	assign push_entry.sum       = sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= SIZE_W'(1);
			col_count_q <= SIZE_W'(1);
			load_row_q  <= '0;
			load_col_q  <= '0;
			left_sum_q  <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_ROW_COUNT) begin
				row_count_q <= cfg_data;
			end
			if (cfg_index == REG_COL_COUNT) begin
				col_count_q <= cfg_data;
			end
			// any write restarts the grid
			load_row_q <= '0;
			load_col_q <= '0;
			left_sum_q <= '0;
		end else if (accept) begin
			if (!last_col) begin
				load_col_q <= load_col_q + COORD_W'(1);
				left_sum_q <= sum;
			end else if (!last_row) begin
				load_col_q <= '0;
				load_row_q <= load_row_q + COORD_W'(1);
				left_sum_q <= sum;
			end else begin
				load_col_q <= '0;
				load_row_q <= '0;
				left_sum_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_sum_q[load_col_q[CIW-1:0]] <= sum;
		end
	end

endmodule

[rtl/core/gmp_queue.sv]
// ----------------------------------------------------------------------------
// gmp_queue
// Short FIFO of classified cells between the front and the back.
// ----------------------------------------------------------------------------
module gmp_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  gmp_pkg::gmp_entry_t  push_entry,
	output logic                 full,
	input  logic                 pop,
	output logic                 head_valid,
	output gmp_pkg::gmp_entry_t  head_entry
);
	import gmp_pkg::*;

	gmp_entry_t        slot_q [QDEPTH];
	logic [QAW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [QAW:0]      count_q;
	logic              do_push, do_pop;

	assign full       = (count_q == (QAW+1)'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (QAW+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (QAW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

[rtl/core/gmp_back.sv]
// ----------------------------------------------------------------------------
// gmp_back
// Stores direction bits, traces the best path back from the last cell and
// emits it from the top-left corner onward through an output register.
// ----------------------------------------------------------------------------
module gmp_back #(
	parameter int MAX_ROWS = gmp_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = gmp_pkg::MAX_COLS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 head_valid,
	input  gmp_pkg::gmp_entry_t                  head_entry,
	output logic                                 pop,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [gmp_pkg::COORD_W-1:0]          path_row,
	output logic [gmp_pkg::COORD_W-1:0]          path_col,
	output logic signed [gmp_pkg::SUM_W-1:0]     best_sum,
	output logic                                 last_of_path
);
	import gmp_pkg::*;

	localparam int DDEPTH = MAX_ROWS * MAX_COLS;
	localparam int DAW    = (DDEPTH > 1) ? $clog2(DDEPTH) : 1;
	localparam int SDEPTH = MAX_ROWS + MAX_COLS - 1;
	localparam int SAW    = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
	localparam int LW     = $clog2(SDEPTH + 1) + 1;

	localparam logic [2:0] B_IDLE       = 3'd0;
	localparam logic [2:0] B_TRACE_RD   = 3'd1;
	localparam logic [2:0] B_TRACE_STEP = 3'd2;
	localparam logic [2:0] B_EMIT_RD    = 3'd3;
	localparam logic [2:0] B_EMIT_LD    = 3'd4;

	logic                        dir_mem [DDEPTH];
	logic [2*COORD_W-1:0]        stack_mem [SDEPTH];

	logic [2:0]                  state_q;
	logic [COORD_W-1:0]          cur_row_q, cur_col_q;
	logic [LW-1:0]               len_q;
	logic [SAW-1:0]              emit_idx_q;
	logic signed [SUM_W-1:0]     sum_q;
	logic                        dir_rd_q;
	logic [2*COORD_W-1:0]        stack_rd_q;

	logic                        out_valid_q, last_q;
	logic [COORD_W-1:0]          out_row_q, out_col_q;
	logic signed [SUM_W-1:0]     out_sum_q;

	logic [DAW-1:0]              head_addr, cur_addr;
	logic [COORD_W-1:0]          nxt_row, nxt_col;
	logic                        out_free, out_load;

	assign pop       = (state_q == B_IDLE) && head_valid;
	assign head_addr = DAW'(head_entry.row * MAX_COLS + head_entry.col);
	assign cur_addr  = DAW'(cur_row_q * MAX_COLS + cur_col_q);
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = (state_q == B_EMIT_LD) && out_free;

	always_comb begin
		nxt_row = cur_row_q;
		nxt_col = cur_col_q;
		if (cur_row_q == '0 || (cur_col_q != '0 && dir_rd_q)) begin
			nxt_col = cur_col_q - COORD_W'(1);
		end else begin
			nxt_row = cur_row_q - COORD_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			len_q       <= '0;
			emit_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (head_valid && head_entry.last) begin
						cur_row_q  <= head_entry.row;
						cur_col_q  <= head_entry.col;
						len_q      <= LW'(1);
						emit_idx_q <= '0;
						if (head_entry.row == '0 && head_entry.col == '0) begin
							state_q <= B_EMIT_RD;
						end else begin
							state_q <= B_TRACE_RD;
						end
					end
				end
				B_TRACE_RD: begin
					state_q <= B_TRACE_STEP;
				end
				B_TRACE_STEP: begin
					cur_row_q <= nxt_row;
					cur_col_q <= nxt_col;
					len_q     <= len_q + LW'(1);
					if (nxt_row == '0 && nxt_col == '0) begin
						emit_idx_q <= len_q[SAW-1:0];
						state_q    <= B_EMIT_RD;
					end else begin
						state_q <= B_TRACE_RD;
					end
				end
				B_EMIT_RD: begin
					state_q <= B_EMIT_LD;
				end
				B_EMIT_LD: begin
					// hold until the output register frees up
					if (out_free) begin
						if (emit_idx_q == '0) begin
							state_q <= B_IDLE;
						end else begin
							emit_idx_q <= emit_idx_q - SAW'(1);
							state_q    <= B_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	// payload and memories
	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && head_valid) begin
			dir_mem[head_addr] <= head_entry.from_left;
			if (head_entry.last) begin
				sum_q        <= head_entry.sum;
				stack_mem[0] <= {head_entry.row, head_entry.col};
			end
		end
		if (state_q == B_TRACE_RD) begin
			dir_rd_q <= dir_mem[cur_addr];
		end
		if (state_q == B_TRACE_STEP) begin
			stack_mem[len_q[SAW-1:0]] <= {nxt_row, nxt_col};
		end
		if (state_q == B_EMIT_RD) begin
			stack_rd_q <= stack_mem[emit_idx_q];
		end
		if (out_load) begin
			out_row_q <= stack_rd_q[2*COORD_W-1:COORD_W];
			out_col_q <= stack_rd_q[COORD_W-1:0];
			out_sum_q <= sum_q;
			last_q    <= (emit_idx_q == '0);
		end
	end

	assign out_valid    = out_valid_q;
	assign path_row     = out_row_q;
	assign path_col     = out_col_q;
	assign best_sum     = out_sum_q;
	assign last_of_path = last_q;

endmodule

[rtl/core/grid_max_path_sum_traceback.sv]
// Throughput: one cell per cycle while a grid streams in and the queue is not full
// (line buffer, one add and compare). Each traceback step has a read and a step state,
// each emitted coordinate a read and a load state (single-port memories).
// Cells of the next grid queue up during traceback; intake stalls once the queue is full.
// Reset: sizes read as 1, grid position and control clear; memories are not cleared.
// ----------------------------------------------------------------------------
// grid_max_path_sum_traceback
// Streams a grid in row-major order, finds the maximum right/down path sum and
// emits the path from top-left to bottom-right after the last cell.
// ----------------------------------------------------------------------------
module grid_max_path_sum_traceback #(
	parameter int MAX_ROWS = gmp_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = gmp_pkg::MAX_COLS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [gmp_pkg::CELL_W-1:0]    cell_value,
	input  logic                                 cfg_we,
	input  logic [gmp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [gmp_pkg::CFG_DATA_W-1:0]       cfg_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [gmp_pkg::COORD_W-1:0]          path_row,
	output logic [gmp_pkg::COORD_W-1:0]          path_col,
	output logic signed [gmp_pkg::SUM_W-1:0]     best_sum,
	output logic                                 last_of_path
);
	import gmp_pkg::*;

	logic        push, q_full, pop, head_valid;
	gmp_entry_t  push_entry, head_entry;

	gmp_front #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.cell_value (cell_value),
		.in_stall   (in_stall),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full)
	);

	gmp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	gmp_back #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_entry   (head_entry),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.path_row     (path_row),
		.path_col     (path_col),
		.best_sum     (best_sum),
		.last_of_path (last_of_path)
	);

endmodule
